// File: rtl/aabb_pkg.sv
// aabb_pkg: shared types and constants for the pairwise box overlap block
// used by aabb_ctrl, aabb_dpath and aabb_pairwise_overlap; no dependencies
package aabb_pkg;

   localparam int DEFAULT_MAX_BOXES = 64;
   localparam int COORD_W           = 32;
   localparam int ID_W              = 16;

   // one stored box: closed min/max corners plus entity tag
   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
      logic        [ID_W-1:0]    id;
   } box_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } ctl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture the new box
      logic wr_en;    // append new box to the store
      logic rd_en;    // read one stored box
      logic take;     // hit counted, shift into pending slot
      logic flush;    // end of scan, emit pending hit as last pair
   } ctl_cmd_type;

endpackage

// File: rtl/aabb_ctrl.sv
// aabb_ctrl: sequencer for the overlap scan, store fill count and hit count
// depends on aabb_pkg
module aabb_ctrl #(
   parameter int MAX_BOXES = aabb_pkg::DEFAULT_MAX_BOXES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         start_new_set,
   input  logic                         hit,
   output logic                         busy,
   output aabb_pkg::ctl_cmd_type        cmd,
   output logic [$clog2(MAX_BOXES)-1:0] wr_addr,
   output logic [$clog2(MAX_BOXES)-1:0] rd_addr
);
   import aabb_pkg::*;

   localparam int AW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int FW = $clog2(MAX_BOXES);
   localparam logic [CW-1:0] FULL = CW'(MAX_BOXES);
   localparam logic [FW-1:0] CAP  = FW'(MAX_BOXES - 1);

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] scan_n_ff, scan_n_in;
   logic [FW-1:0] found_ff, found_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0] base;

   assign base    = start_new_set ? '0 : count_ff;
   assign wr_addr = base[AW-1:0];
   assign rd_addr = idx_ff[AW-1:0];
   assign busy    = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         scan_n_ff  <= '0;
         found_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         scan_n_ff  <= scan_n_in;
         found_ff   <= found_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      scan_n_in   = scan_n_ff;
      found_in    = found_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               cmd.wr_en = (base != FULL);
               scan_n_in = base;
               idx_in    = '0;
               found_in  = '0;
               count_in  = (base != FULL) ? base + CW'(1) : base;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = (idx_ff != scan_n_ff);
            if (cmd.rd_en) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // hits past the result cap are dropped
      cmd.take = cmp_vld_ff && hit && (found_ff != CAP);
      if (cmd.take) begin
         found_in = found_ff + FW'(1);
      end
      cmp_vld_in = cmd.rd_en;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL) else $error("store count beyond capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= scan_n_ff))
      else $error("scan index past scan length");

   a_idle_no_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !cmp_vld_ff)
      else $error("compare pending while idle");

   a_flush_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> ($past(state_ff) == ST_SCAN))
      else $error("flush without scan");

endmodule

// File: rtl/aabb_dpath.sv
// aabb_dpath: box store, overlap compare, pending hit slot and result registers
// depends on aabb_pkg; driven by aabb_ctrl commands
module aabb_dpath #(
   parameter int MAX_BOXES = aabb_pkg::DEFAULT_MAX_BOXES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  aabb_pkg::ctl_cmd_type                cmd,
   input  logic [$clog2(MAX_BOXES)-1:0]         wr_addr,
   input  logic [$clog2(MAX_BOXES)-1:0]         rd_addr,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_min_x,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_min_y,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_min_z,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_max_x,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_max_y,
   input  logic signed [aabb_pkg::COORD_W-1:0]  box_max_z,
   input  logic        [aabb_pkg::ID_W-1:0]     entity_id,
   output logic                                 hit,
   output logic                                 rsp_valid,
   output logic        [aabb_pkg::ID_W-1:0]     rsp_new_entity_id,
   output logic        [aabb_pkg::ID_W-1:0]     rsp_earlier_entity_id,
   output logic                                 rsp_last_pair
);
   import aabb_pkg::*;

   box_type           mem_ff [MAX_BOXES];
   box_type           new_box;
   box_type           cur_ff;
   box_type           rd_ff;
   logic              pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic              out_vld_ff, out_vld_in;
   logic              out_last_ff, out_last_in;
   logic [ID_W-1:0]   out_earlier_ff, out_earlier_in;
   logic [ID_W-1:0]   out_new_ff, out_new_in;

   assign new_box = '{min_x: box_min_x, min_y: box_min_y, min_z: box_min_z,
                      max_x: box_max_x, max_y: box_max_y, max_z: box_max_z,
                      id: entity_id};

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= new_box;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
      if (cmd.load) begin
         cur_ff <= new_box;
      end
   end

   // closed boxes: touching bounds count as overlap
   assign hit = (cur_ff.min_x <= rd_ff.max_x) && (rd_ff.min_x <= cur_ff.max_x) &&
                (cur_ff.min_y <= rd_ff.max_y) && (rd_ff.min_y <= cur_ff.max_y) &&
                (cur_ff.min_z <= rd_ff.max_z) && (rd_ff.min_z <= cur_ff.max_z);

   // a hit waits in the pending slot until the next hit or the end of scan
   always_comb begin
      pend_vld_in    = pend_vld_ff;
      pend_id_in     = pend_id_ff;
      out_vld_in     = 1'b0;
      out_last_in    = out_last_ff;
      out_earlier_in = out_earlier_ff;
      out_new_in     = out_new_ff;
      if (cmd.take) begin
         pend_vld_in = 1'b1;
         pend_id_in  = rd_ff.id;
         if (pend_vld_ff) begin
            out_vld_in     = 1'b1;
            out_last_in    = 1'b0;
            out_earlier_in = pend_id_ff;
            out_new_in     = cur_ff.id;
         end
      end else if (cmd.flush) begin
         pend_vld_in = 1'b0;
         if (pend_vld_ff) begin
            out_vld_in     = 1'b1;
            out_last_in    = 1'b1;
            out_earlier_in = pend_id_ff;
            out_new_in     = cur_ff.id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      pend_id_ff     <= pend_id_in;
      out_last_ff    <= out_last_in;
      out_earlier_ff <= out_earlier_in;
      out_new_ff     <= out_new_in;
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_last_pair         = out_last_ff;
   assign rsp_earlier_entity_id = out_earlier_ff;
   assign rsp_new_entity_id     = out_new_ff;

   a_take_flush_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.flush)) else $error("take and flush together");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_vld_ff) else $error("pending hit survives flush");

   a_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_last_ff) |-> $past(cmd.flush))
      else $error("last pair without end of scan");

endmodule

// File: rtl/aabb_pairwise_overlap.sv
// aabb_pairwise_overlap: top level of the incremental all-pairs box overlap test
// depends on aabb_pkg, aabb_ctrl and aabb_dpath
//
// Each transfer on the req_ side carries one axis-aligned box (signed Q16.16
// closed corners) and an entity tag. It is accepted on a clock edge with start
// high and busy low. The box is compared against every stored box in storage
// order, one stored box per cycle, and for every overlap a pair (new tag,
// earlier tag) comes out on the rsp_ ports for exactly one cycle with
// rsp_valid high; the final pair of an item has rsp_last_pair set. The
// receiver cannot stall: each pair must be taken in the cycle it is shown.
// At most MAX_BOXES-1 pairs are produced per item; further overlaps are
// dropped. req_start_new_set empties the store before the item is handled.
// The new box is appended to the store at accept time unless the store
// already holds MAX_BOXES boxes, in which case it is compared but not kept.
// An item keeps busy high while the scanned stored boxes, 0 to MAX_BOXES of
// them, are read from the box store in turn, then through the final compare
// and the end-of-item flush. The last pair of an item is shown in the first
// cycle that busy is low, so the next transfer may be accepted while it is
// shown.
module aabb_pairwise_overlap #(
   parameter int MAX_BOXES = aabb_pkg::DEFAULT_MAX_BOXES
) (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_start_new_set,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_min_x,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_min_y,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_min_z,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_max_x,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_max_y,
   input  logic signed [aabb_pkg::COORD_W-1:0] req_box_max_z,
   input  logic        [aabb_pkg::ID_W-1:0]    req_entity_id,
   // result side, one-cycle strobe
   output logic                                rsp_valid,
   output logic        [aabb_pkg::ID_W-1:0]    rsp_new_entity_id,
   output logic        [aabb_pkg::ID_W-1:0]    rsp_earlier_entity_id,
   output logic                                rsp_last_pair
);
   import aabb_pkg::*;

   localparam int AW = $clog2(MAX_BOXES);

   ctl_cmd_type   cmd;
   logic          hit;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   // sequencer: store count, scan index, result cap
   aabb_ctrl #(
      .MAX_BOXES (MAX_BOXES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .start_new_set (req_start_new_set),
      .hit           (hit),
      .busy          (busy),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr)
   );

   // box store, compare and result registers
   aabb_dpath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .wr_addr               (wr_addr),
      .rd_addr               (rd_addr),
      .box_min_x             (req_box_min_x),
      .box_min_y             (req_box_min_y),
      .box_min_z             (req_box_min_z),
      .box_max_x             (req_box_max_x),
      .box_max_y             (req_box_max_y),
      .box_max_z             (req_box_max_z),
      .entity_id             (req_entity_id),
      .hit                   (hit),
      .rsp_valid             (rsp_valid),
      .rsp_new_entity_id     (rsp_new_entity_id),
      .rsp_earlier_entity_id (rsp_earlier_entity_id),
      .rsp_last_pair         (rsp_last_pair)
   );

endmodule
